// ===== rtl/b64d_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the character lookup for the base64 stream
// decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  // Result buffer depth (entries); one input transfer writes at most three.
  localparam int unsigned RES_DEPTH   = 8;
  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned SEXTET_W    = 6;
  localparam int unsigned GROUP_W     = 3 * SEXTET_W;

  // Sextet codes for the two letters that have two spellings each
  localparam logic [SEXTET_W-1:0] SEXTET_62 = 6'd62;
  localparam logic [SEXTET_W-1:0] SEXTET_63 = 6'd63;

  // One result as seen on the output channel
  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       last;
  } result_t;

  // Lookup result for one character
  typedef struct packed {
    logic                hit;
    logic [SEXTET_W-1:0] value;
  } sextet_t;

  // Map one character to its sextet; hit is low outside the alphabet
  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t r;
    r.hit   = 1'b1;
    r.value = '0;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r.value = SEXTET_W'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      r.value = SEXTET_W'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.value = SEXTET_W'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2b || c == 8'h2d) begin
      r.value = SEXTET_62;
    end else if (c == 8'h2f || c == 8'h5f) begin
      r.value = SEXTET_63;
    end else begin
      r.hit = 1'b0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/base64url_stream_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// base64url_stream_decoder
// Decodes base64 / base64url text one character per transfer into bytes.
// ----------------------------------------------------------------------------
// Results are registered into the result buffer and shown once earlier ones drain.
// Throughput: one character per cycle while the 8-entry result buffer has
//   room for three results; output drains one result per cycle while out_ready
//   is high, so a stream of four characters per three bytes runs without stalls.
// Reset: clears the sextet buffer, group count, stop flag and empties the
//   result buffer; no clearing pass is needed.
module base64url_stream_decoder #(
  parameter int unsigned RES_DEPTH = b64d_pkg::RES_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_char,
  input  wire logic       end_of_text,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            byte_valid,
  output logic            last
);

  localparam int unsigned PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned CNT_W = $clog2(RES_DEPTH + 1);
  localparam int unsigned SX_W  = b64d_pkg::SEXTET_W;
  localparam int unsigned BUF_W = b64d_pkg::GROUP_W;
  localparam int unsigned MAXR  = b64d_pkg::MAX_RESULTS;

  // Decoder state
  logic [BUF_W-1:0] sextet_buffer, sextet_buffer_next;
  logic [1:0]       group_count, group_count_next;
  logic             stopped, stopped_next;

  // Result buffer
  b64d_pkg::result_t res_mem [RES_DEPTH];
  logic [PTR_W-1:0]  head, tail;
  logic [CNT_W-1:0]  count, count_next;

  logic              in_xfer, out_xfer;
  b64d_pkg::sextet_t sx;
  b64d_pkg::result_t ent [MAXR];
  logic [1:0]        push_n;
  logic [BUF_W-1:0]  buf_mid;
  logic [1:0]        cnt_mid;
  logic [BUF_W+SX_W-1:0] full_group;

  assign in_ready  = (count <= CNT_W'(RES_DEPTH - MAXR));
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = (count != '0);
  assign out_xfer  = out_valid && out_ready;

  assign sx         = b64d_pkg::sextet_of(in_char);
  assign full_group = {sextet_buffer, sx.value};

  // Decode one character and its end-of-text tail
  always_comb begin
    sextet_buffer_next = sextet_buffer;
    group_count_next   = group_count;
    stopped_next       = stopped;
    buf_mid            = sextet_buffer;
    cnt_mid            = group_count;
    push_n             = 2'd0;
    for (int i = 0; i < MAXR; i++) begin
      ent[i] = '0;
    end

    if (!stopped) begin
      if (!sx.hit) begin
        stopped_next = 1'b1;
      end else if (group_count == 2'd3) begin
        ent[0].data       = full_group[23:16];
        ent[0].byte_valid = 1'b1;
        ent[1].data       = full_group[15:8];
        ent[1].byte_valid = 1'b1;
        ent[2].data       = full_group[7:0];
        ent[2].byte_valid = 1'b1;
        push_n            = 2'd3;
        buf_mid           = '0;
        cnt_mid           = 2'd0;
      end else begin
        buf_mid = {sextet_buffer[BUF_W-SX_W-1:0], sx.value};
        cnt_mid = group_count + 2'd1;
      end
    end
    sextet_buffer_next = buf_mid;
    group_count_next   = cnt_mid;

    if (end_of_text) begin
      // Emit the zero-filled partial group and mark the final result; with no byte due, emit a byteless end marker
      priority case (1'b1)
        cnt_mid == 2'd2: begin
          ent[0].data       = buf_mid[11:4];
          ent[0].byte_valid = 1'b1;
          ent[0].last       = 1'b1;
          push_n            = 2'd1;
        end
        cnt_mid == 2'd3: begin
          ent[0].data       = buf_mid[17:10];
          ent[0].byte_valid = 1'b1;
          ent[1].data       = buf_mid[9:2];
          ent[1].byte_valid = 1'b1;
          ent[1].last       = 1'b1;
          push_n            = 2'd2;
        end
        push_n == 2'd3: begin
          ent[2].last = 1'b1;
        end
        default: begin
          ent[0] = '{data: 8'h00, byte_valid: 1'b0, last: 1'b1};
          push_n = 2'd1;
        end
      endcase
      sextet_buffer_next = '0;
      group_count_next   = 2'd0;
      stopped_next       = 1'b0;
    end
  end

  // Advance decoder state on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      sextet_buffer <= '0;
      group_count   <= 2'd0;
      stopped       <= 1'b0;
    end else if (in_xfer) begin
      sextet_buffer <= sextet_buffer_next;
      group_count   <= group_count_next;
      stopped       <= stopped_next;
    end
  end

  // Write new results into the buffer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      for (int i = 0; i < MAXR; i++) begin
        if (2'(i) < push_n) begin
          res_mem[PTR_W'(tail + PTR_W'(i))] <= ent[i];
        end
      end
    end
  end

  assign count_next = count + (in_xfer ? CNT_W'(push_n) : '0)
                            - (out_xfer ? CNT_W'(1) : '0);

  // Track buffer pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (in_xfer) begin
        tail <= PTR_W'(tail + PTR_W'(push_n));
      end
      if (out_xfer) begin
        head <= PTR_W'(head + PTR_W'(1));
      end
    end
  end

  // Present the oldest result
  assign out_byte   = res_mem[head].data;
  assign byte_valid = res_mem[head].byte_valid;
  assign last       = res_mem[head].last;

  // Buffer never overfills
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(RES_DEPTH))
    else $error("result buffer overflow");

  // End of text leaves the decoder cleared
  a_eot_clears: assert property (@(posedge clk) disable iff (rst)
    in_xfer && end_of_text |=> group_count == 2'd0 && !stopped && sextet_buffer == '0)
    else $error("state not cleared after end of text");

  // Every end-of-text transfer writes at least one result
  a_eot_pushes: assert property (@(posedge clk) disable iff (rst)
    in_xfer && end_of_text |-> push_n != 2'd0)
    else $error("end of text produced no result");

endmodule
`default_nettype wire

// ===== tb/b64_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// b64_result_checker
// Watches both channels of the base64 stream decoder. It decodes each
// accepted character on its own copy of the decoder state, queues the
// bytes that are due, and compares every accepted result with the oldest
// queued one.
// ----------------------------------------------------------------------------
module b64_result_checker (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       in_ready,
  input  wire logic [7:0] in_char,
  input  wire logic       end_of_text,
  input  wire logic       out_valid,
  input  wire logic       out_ready,
  input  wire logic [7:0] out_byte,
  input  wire logic       byte_valid,
  input  wire logic       last,
  output int              error_count,
  output int              results_waiting
);

  // Decoder state as predicted
  logic [b64d_pkg::GROUP_W-1:0] sextet_buf;
  logic [1:0]                   group_cnt;
  logic                         halted;

  b64d_pkg::result_t due_results[$];

  // Map a character to its sextet; both alphabets share codes 62 and 63
  function automatic b64d_pkg::sextet_t char_to_sextet(input logic [7:0] c);
    b64d_pkg::sextet_t s;
    s.hit   = 1'b1;
    s.value = '0;
    if (c >= "A" && c <= "Z") begin
      s.value = 6'(c - "A");
    end else if (c >= "a" && c <= "z") begin
      s.value = 6'(c - "a" + 8'd26);
    end else if (c >= "0" && c <= "9") begin
      s.value = 6'(c - "0" + 8'd52);
    end else if (c == "+" || c == "-") begin
      s.value = 6'd62;
    end else if (c == "/" || c == "_") begin
      s.value = 6'd63;
    end else begin
      s.hit = 1'b0;
    end
    return s;
  endfunction

  function automatic b64d_pkg::result_t make_result(input logic [7:0] d, input logic v,
                                                     input logic l);
    b64d_pkg::result_t r;
    r.data       = d;
    r.byte_valid = v;
    r.last       = l;
    return r;
  endfunction

  // Decode one accepted character and queue the results it causes
  task automatic decode_transfer(input logic [7:0] c, input logic eot);
    b64d_pkg::sextet_t s;
    b64d_pkg::result_t res [3];
    int                n;
    logic [23:0]       word;
    n = 0;
    if (!halted) begin
      s = char_to_sextet(c);
      if (!s.hit) begin
        // '=' or a foreign character: stop until the end of the text
        halted = 1'b1;
      end else if (group_cnt == 2'd3) begin
        word      = {sextet_buf, s.value};
        res[0]    = make_result(word[23:16], 1'b1, 1'b0);
        res[1]    = make_result(word[15:8], 1'b1, 1'b0);
        res[2]    = make_result(word[7:0], 1'b1, 1'b0);
        n         = 3;
        sextet_buf = '0;
        group_cnt  = 2'd0;
      end else begin
        sextet_buf = {sextet_buf[11:0], s.value};
        group_cnt  = group_cnt + 2'd1;
      end
    end
    if (eot) begin
      // Flush the zero-filled partial group; a lone sextet gives nothing
      if (group_cnt == 2'd2) begin
        word     = {sextet_buf[11:0], 12'h000};
        res[n]   = make_result(word[23:16], 1'b1, 1'b0);
        n        = n + 1;
      end else if (group_cnt == 2'd3) begin
        word     = {sextet_buf, 6'd0};
        res[n]   = make_result(word[23:16], 1'b1, 1'b0);
        res[n+1] = make_result(word[15:8], 1'b1, 1'b0);
        n        = n + 2;
      end
      if (n == 0) begin
        res[0] = make_result(8'h00, 1'b0, 1'b1);
        n      = 1;
      end else begin
        res[n-1].last = 1'b1;
      end
      sextet_buf = '0;
      group_cnt  = 2'd0;
      halted     = 1'b0;
    end
    for (int i = 0; i < n; i++) begin
      due_results = {due_results, res[i]};
    end
  endtask

  // Predict on input transfers, compare on output transfers
  always @(posedge clk) begin : watch
    b64d_pkg::result_t want;
    if (rst) begin
      sextet_buf  = '0;
      group_cnt   = 2'd0;
      halted      = 1'b0;
      error_count = 0;
      due_results.delete();
    end else begin
      if (in_valid && in_ready) begin
        decode_transfer(in_char, end_of_text);
      end
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result: expected none, got byte=%02h valid=%b last=%b",
                   $time, out_byte, byte_valid, last);
        end else begin
          want = due_results.pop_front();
          if (want.data !== out_byte || want.byte_valid !== byte_valid ||
              want.last !== last) begin
            error_count++;
            $display("%0t: mismatch (byte/valid/last): expected %02h/%b/%b, got %02h/%b/%b",
                     $time, want.data, want.byte_valid, want.last,
                     out_byte, byte_valid, last);
          end
        end
      end
    end
    results_waiting <= due_results.size();
  end

endmodule

// ===== tb/base64url_stream_decoder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// base64url_stream_decoder_tb
// Drives the base64 stream decoder with directed texts and then with random
// encoded texts, broken texts and noise, under changing idle patterns on
// both channels. A side checker predicts and compares every result.
// ----------------------------------------------------------------------------
module base64url_stream_decoder_tb;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 7;
  localparam int HOLD_CYCLES  = 120;
  localparam int PHASE_CHARS  = 84;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;

  logic       clk         = 1'b0;
  logic       rst         = 1'b1;
  logic       in_valid    = 1'b0;
  logic       in_ready;
  logic [7:0] in_char     = 8'h00;
  logic       end_of_text = 1'b0;
  logic       out_valid;
  logic       out_ready   = 1'b0;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       last;

  int send_idle   = 0;
  int recv_idle   = 0;
  int hold_id     = 0;
  int hold_seen   = 0;
  int hold_left   = 0;
  int cycle_count = 0;
  int sent_chars  = 0;
  int error_count;
  int results_waiting;

  logic [7:0] text_q[$];

  always #CLK_HALF clk = ~clk;

  base64url_stream_decoder dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_char    (in_char),
    .end_of_text(end_of_text),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .last       (last)
  );

  b64_result_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char        (in_char),
    .end_of_text    (end_of_text),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .byte_valid     (byte_valid),
    .last           (last),
    .error_count    (error_count),
    .results_waiting(results_waiting)
  );

  // Stall the output at random; hold off for a long stretch on request
  always @(posedge clk) begin
    if (hold_id != hold_seen) begin
      hold_seen = hold_id;
      hold_left = HOLD_CYCLES;
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [7:0] sextet_char(input logic [5:0] s, input bit url);
    if (s < 6'd26) return 8'("A" + s);
    if (s < 6'd52) return 8'("a" + s - 8'd26);
    if (s < 6'd62) return 8'("0" + s - 8'd52);
    if (s == 6'd62) return url ? "-" : "+";
    return url ? "_" : "/";
  endfunction

  // Add one character at the end of the text
  function automatic void append_char(input logic [7:0] c);
    text_q = {text_q, c};
  endfunction

  // Append the encoding of nbytes random bytes to the text
  function automatic void add_encoded(input int nbytes, input bit url, input bit pad);
    logic [23:0] w;
    int          i;
    for (i = 0; i + 3 <= nbytes; i += 3) begin
      w = 24'($urandom);
      append_char(sextet_char(w[23:18], url));
      append_char(sextet_char(w[17:12], url));
      append_char(sextet_char(w[11:6], url));
      append_char(sextet_char(w[5:0], url));
    end
    if (nbytes % 3 == 1) begin
      w = {8'($urandom), 16'h0000};
      append_char(sextet_char(w[23:18], url));
      append_char(sextet_char(w[17:12], url));
      if (pad) begin
        append_char("=");
        append_char("=");
      end
    end else if (nbytes % 3 == 2) begin
      w = {16'($urandom), 8'h00};
      append_char(sextet_char(w[23:18], url));
      append_char(sextet_char(w[17:12], url));
      append_char(sextet_char(w[11:6], url));
      if (pad) begin
        append_char("=");
      end
    end
  endfunction

  function automatic void add_string(input string s);
    for (int i = 0; i < s.len(); i++) begin
      append_char(s[i]);
    end
  endfunction

  // Offer one character and hold it until the transfer
  task automatic send_char(input logic [7:0] c, input logic eot);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_char     <= c;
    end_of_text <= eot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Send the queued text, flagging its final character
  task automatic send_text();
    sent_chars += text_q.size();
    for (int i = 0; i < text_q.size(); i++) begin
      send_char(text_q[i], i == text_q.size() - 1);
    end
    text_q.delete();
  endtask

  // Pause the input until every due result has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_waiting != 0) @(posedge clk);
  endtask

  // Build one random text: mostly well formed, some broken, some noise
  task automatic random_text();
    int         kind;
    int         n;
    int         pos;
    bit         url;
    logic [7:0] stop_c;
    string      punct;
    punct = "!*.:~ ";
    kind  = $urandom_range(99);
    url   = 1'($urandom_range(1));
    n     = ($urandom_range(9) == 0) ? $urandom_range(30) : $urandom_range(9);
    if (kind < 70) begin
      add_encoded(n, url, 1'($urandom_range(1)));
      // leave a lone trailing sextet now and then
      if (n % 3 == 0 && $urandom_range(3) == 0) begin
        append_char(sextet_char(6'($urandom), url));
      end
    end else if (kind < 85) begin
      add_encoded(n, url, 1'b0);
      case ($urandom_range(2))
        0:       stop_c = "=";
        1:       stop_c = 8'h80 | 8'($urandom_range(127));
        default: stop_c = punct[$urandom_range(punct.len() - 1)];
      endcase
      pos = $urandom_range(text_q.size());
      text_q.insert(pos, stop_c);
    end else begin
      n = $urandom_range(1, 6);
      repeat (n) append_char(8'($urandom_range(255)));
    end
    if (text_q.size() == 0) begin
      append_char(8'($urandom_range(255)));
    end
    send_text();
  endtask

  task automatic run_phase(input int s_idle, input int r_idle);
    send_idle  = s_idle;
    recv_idle  = r_idle;
    sent_chars = 0;
    while (sent_chars < PHASE_CHARS) random_text();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle = 12;
    recv_idle = 45;

    // all four two-spelling letters; group completed by the final char
    add_string("-_+/");
    send_text();
    // alphabet extremes, then a two-sextet tail
    add_string("AZaz09");
    send_text();
    // three-sextet tail
    add_string("QUI");
    send_text();
    // lone trailing sextet gives only the end marker
    add_string("Q");
    send_text();
    // padding stops decoding; the letter after it is ignored
    add_string("QQ=Z");
    send_text();
    // a high code stops decoding
    add_string("Q");
    append_char(8'hFF);
    add_string("A");
    send_text();
    // a foreign final character with nothing due
    append_char(8'h00);
    send_text();

    // hold the output so the result buffer fills and stalls the input
    hold_id <= hold_id + 1;
    repeat (3) begin
      add_encoded(12, 1'b1, 1'b0);
      send_text();
    end
    wait_drained();

    run_phase(12, 45);
    run_phase(45, 12);
    run_phase(0, 0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && results_waiting == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
